FILE: rtl/stam_pkg.sv
// ----------------------------------------------------------------------------
// stam_pkg
// Shared types, constants and arithmetic helpers of the stall time monitor.
// ----------------------------------------------------------------------------
package stam_pkg;

  localparam int DEF_MAX_DOMAINS = 16;

  localparam int NS_W  = 64;
  localparam int DOM_W = 31;
  localparam int CNT_W = 16;
  localparam int AVG_W = 17;
  localparam int BP_W  = 14;
  localparam int QF    = 16;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [AVG_W-1:0] Q_ONE     = 17'h10000;
  localparam logic [15:0]      DECAY10   = 16'd59303;
  localparam logic [15:0]      DECAY60   = 16'd64453;
  localparam logic [15:0]      DECAY300  = 16'd65318;
  localparam logic [BP_W-1:0]  BP_SCALE  = 14'd10000;
  localparam logic [BP_W-1:0]  THR_RESET = 14'd10000;

  typedef enum logic [2:0] {
    REQ_ENTER       = 3'd0,
    REQ_EXIT        = 3'd1,
    REQ_BUSY        = 3'd2,
    REQ_SAMPLE      = 3'd3,
    REQ_AGGREGATE   = 3'd4,
    REQ_READ_GLOBAL = 3'd5,
    REQ_READ_DOMAIN = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TABLE_FULL = 2'd1,
    ST_UNDERFLOW  = 2'd2
  } status_t;

  typedef logic [2:0][AVG_W-1:0] avg3_t;

  typedef struct packed {
    logic [DOM_W-1:0] domain;
    logic [CNT_W-1:0] stalled;
    logic [NS_W-1:0]  some_start;
    logic [NS_W-1:0]  some_banked;
    logic [NS_W-1:0]  full_banked;
    logic [NS_W-1:0]  prev_full;
    avg3_t            avg;
  } slot_rec_t;

  function automatic logic [NS_W-1:0] live_total(input logic [NS_W-1:0] banked,
                                                 input logic [CNT_W-1:0] count,
                                                 input logic [NS_W-1:0] start,
                                                 input logic [NS_W-1:0] now);
    if (count != '0 && now > start) return banked + (now - start);
    return banked;
  endfunction

  function automatic logic [BP_W-1:0] to_bp(input logic [AVG_W-1:0] avg);
    logic [AVG_W+BP_W-1:0] p;
    p = (AVG_W+BP_W)'(avg) * (AVG_W+BP_W)'(BP_SCALE);
    return p[QF+BP_W-1:QF];
  endfunction

  function automatic logic [15:0] decay_of(input int k);
    case (k)
      0:       return DECAY10;
      1:       return DECAY60;
      default: return DECAY300;
    endcase
  endfunction

endpackage

FILE: rtl/stam_slot_mem.sv
// ----------------------------------------------------------------------------
// stam_slot_mem
// Domain slot table: one record per slot, one write and one registered read.
// ----------------------------------------------------------------------------
module stam_slot_mem import stam_pkg::*; #(
  parameter int DEPTH = DEF_MAX_DOMAINS,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  slot_rec_t       wdata,
  input  logic [AW-1:0]   raddr,
  output slot_rec_t       rdata
);

  slot_rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/stam_frac_div.sv
// ----------------------------------------------------------------------------
// stam_frac_div
// Q16 fraction num/den clamped to one, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stam_frac_div import stam_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NS_W-1:0]  num,
  input  logic [NS_W-1:0]  den,
  output logic             done,
  output logic [AVG_W-1:0] quot
);

  logic [NS_W-1:0] r;
  logic [NS_W-1:0] d;
  logic [QF-1:0]   q;
  logic [4:0]      cnt;
  logic            run;
  logic            sat;
  logic [NS_W-1:0] diff;

  assign diff = d - r;
  assign quot = sat ? Q_ONE : {1'b0, q};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      sat  <= 1'b0;
    end else if (start) begin
      r    <= num;
      d    <= den;
      q    <= '0;
      sat  <= (num >= den);
      cnt  <= (num >= den) ? 5'd0 : 5'd16;
      run  <= 1'b1;
      done <= 1'b0;
    end else if (run) begin
      if (cnt == 5'd0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end else begin
        // 2r stays below den whenever the doubling arm is taken
        if (r >= diff) begin
          r <= r - diff;
          q <= {q[QF-2:0], 1'b1};
        end else begin
          r <= r + r;
          q <= {q[QF-2:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
      end
    end
  end

endmodule

FILE: rtl/stam_ewma3.sv
// ----------------------------------------------------------------------------
// stam_ewma3
// Folds one Q16 fraction into the 10/60/300 s averages, truncating.
// ----------------------------------------------------------------------------
module stam_ewma3 import stam_pkg::*; (
  input  avg3_t            avg,
  input  logic [AVG_W-1:0] frac,
  output avg3_t            avg_next
);

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic [33:0] acc;
    always_comb begin
      acc = 34'(avg[k]) * 34'(decay_of(k))
          + 34'(frac) * 34'(Q_ONE - 17'(decay_of(k)));
      avg_next[k] = acc[QF+AVG_W-1:QF];
    end
  end

endmodule

FILE: rtl/stall_time_accounting_monitor.sv
// ----------------------------------------------------------------------------
// stall_time_accounting_monitor
// Stall time accounting with per-domain slot table and decaying averages.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream (kind in s_tuser), one result per request
// leaves on the m_ stream. The user must write the threshold register on cfg_
// only while the block is idle; this is not enforced. cfg_ready is always high.
// One request is worked on at a time; s_tready is high only when idle.
// Request handling is set by the walk over the slot memory (one read port):
//   read global / unknown: no walk, read domain: one slot read,
//   enter / exit / busy report and sample: a walk over every slot,
//   aggregate: the global averages, then each used slot, each through the
//   shared 16-step fraction divider.
// Results sit in an output register: a stalled receiver does not block the
// next request from being accepted, only its result from being delivered.
// Reset clears all counters, totals and averages and marks every slot free;
// slot records are rewritten on claim, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module stall_time_accounting_monitor import stam_pkg::*; #(
  parameter int MAX_DOMAINS = DEF_MAX_DOMAINS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,  // domain_id[30:0], slot_index[34:31], now_ns[98:35]
  input  logic [2:0]   s_tuser,  // req_type[2:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[1:0], read_domain_id[32:2], slot_in_use[33], some_total_ns[97:34],
  // full_total_ns[161:98], some_avg10/60/300_bp[203:162],
  // full_total averages 10/60/300 s in bp[245:204], above_threshold[246]
  output logic [247:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [13:0]  cfg_data  // full_trigger_threshold_bp[13:0]
);

  localparam int SLOT_W = (MAX_DOMAINS > 1) ? $clog2(MAX_DOMAINS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_DOMAINS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_APPLY, S_WALK, S_AG_START, S_AG_WAIT,
    S_AS_RD, S_AS_CHK, S_AS_START, S_AS_WAIT, S_RDDOM, S_FIN
  } state_t;

  state_t state;

  // request
  req_t             req_q;
  logic [DOM_W-1:0] dom_q;
  logic [3:0]       sidx_q;
  logic [NS_W-1:0]  now_q;
  status_t          status_q;

  // global state
  logic [BP_W-1:0]        thr;
  logic [CNT_W-1:0]       stalled_count;
  logic [NS_W-1:0]        some_start;
  logic [NS_W-1:0]        some_banked;
  logic [NS_W-1:0]        full_banked;
  logic [NS_W-1:0]        last_sample;
  logic                   any_busy;
  logic [MAX_DOMAINS-1:0] busy_mask;
  logic [MAX_DOMAINS-1:0] slot_used;
  avg3_t                  gsome;
  avg3_t                  gfull;
  logic [NS_W-1:0]        prev_some;
  logic [NS_W-1:0]        prev_full;
  logic [NS_W-1:0]        last_agg;

  // walk and scratch
  logic [SLOT_W-1:0] ridx;
  logic              chk_v;
  logic [SLOT_W-1:0] chk_idx;
  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  slot_rec_t         hit_rec;
  logic              samp_en;
  logic [NS_W-1:0]   dt;
  logic [NS_W-1:0]   period;
  logic [NS_W-1:0]   g_some;
  logic [NS_W-1:0]   g_full;
  logic              ph;
  slot_rec_t         arec;
  logic [NS_W-1:0]   ajf;

  // domain read result
  logic              dom_res;
  logic [DOM_W-1:0]  d_id;
  logic              d_inuse;
  logic [NS_W-1:0]   d_some;
  logic [NS_W-1:0]   d_full;
  avg3_t             d_avg;

  // output register
  status_t           o_status;
  logic [DOM_W-1:0]  o_id;
  logic              o_inuse;
  logic [NS_W-1:0]   o_some;
  logic [NS_W-1:0]   o_full;
  logic [BP_W-1:0]   o_bp [6];
  logic              o_above;

  // memory, divider, averages
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  slot_rec_t         mem_wdata;
  logic [SLOT_W-1:0] mem_raddr;
  slot_rec_t         mem_q;
  logic              div_start;
  logic [NS_W-1:0]   div_num;
  logic              div_done;
  logic [AVG_W-1:0]  div_quot;
  avg3_t             ew_in;
  avg3_t             ew_out;

  logic              free_any;
  logic [SLOT_W-1:0] free_idx;
  slot_rec_t         apply_rec;
  logic              apply_can;
  logic [SLOT_W-1:0] apply_idx;
  logic [NS_W-1:0]   q_js;
  logic [NS_W-1:0]   q_jf;
  logic [NS_W-1:0]   glive;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  stam_slot_mem #(.DEPTH(MAX_DOMAINS), .AW(SLOT_W)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_q)
  );

  stam_frac_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(period),
    .done(div_done), .quot(div_quot)
  );

  stam_ewma3 u_ewma (.avg(ew_in), .frac(div_quot), .avg_next(ew_out));

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = MAX_DOMAINS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign q_js  = live_total(mem_q.some_banked, mem_q.stalled, mem_q.some_start, now_q);
  assign q_jf  = (mem_q.full_banked > q_js) ? q_js : mem_q.full_banked;
  assign glive = live_total(some_banked, stalled_count, some_start, now_q);

  // enter / exit update of the claimed slot
  always_comb begin
    apply_can = hit || free_any;
    apply_idx = hit ? hit_idx : free_idx;
    if (hit) begin
      apply_rec = hit_rec;
    end else begin
      apply_rec        = '0;
      apply_rec.domain = dom_q;
    end
    if (req_q == REQ_ENTER) begin
      if (apply_rec.stalled == '0) apply_rec.some_start = now_q;
      if (apply_rec.stalled != COUNT_MAX) apply_rec.stalled = apply_rec.stalled + 1'b1;
    end else if (apply_rec.stalled != '0) begin
      if (apply_rec.stalled == CNT_W'(1) && now_q > apply_rec.some_start) begin
        apply_rec.some_banked = apply_rec.some_banked + (now_q - apply_rec.some_start);
      end
      apply_rec.stalled = apply_rec.stalled - 1'b1;
    end
  end

  always_comb begin
    mem_raddr = (state == S_DISPATCH) ? SLOT_W'(sidx_q) : ridx;
    mem_we    = 1'b0;
    mem_waddr = chk_idx;
    mem_wdata = mem_q;
    div_start = 1'b0;
    div_num   = ph ? (g_full - prev_full) : (g_some - prev_some);
    ew_in     = ph ? gfull : gsome;
    unique case (state)
      S_APPLY: begin
        mem_we    = (req_q == REQ_ENTER || req_q == REQ_EXIT) && apply_can;
        mem_waddr = apply_idx;
        mem_wdata = apply_rec;
      end
      S_WALK: begin
        mem_we = chk_v && samp_en && slot_used[chk_idx] && mem_q.stalled != '0
                 && !busy_mask[chk_idx];
        mem_wdata.full_banked = mem_q.full_banked + dt;
      end
      S_AG_START: div_start = 1'b1;
      S_AS_START: begin
        div_start = 1'b1;
        div_num   = ajf - arec.prev_full;
      end
      S_AS_WAIT: begin
        ew_in               = arec.avg;
        mem_we              = div_done;
        mem_waddr           = ridx;
        mem_wdata           = arec;
        mem_wdata.avg       = ew_out;
        mem_wdata.prev_full = ajf;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      thr           <= THR_RESET;
      stalled_count <= '0;
      some_start    <= '0;
      some_banked   <= '0;
      full_banked   <= '0;
      last_sample   <= '0;
      any_busy      <= 1'b0;
      busy_mask     <= '0;
      slot_used     <= '0;
      gsome         <= '0;
      gfull         <= '0;
      prev_some     <= '0;
      prev_full     <= '0;
      last_agg      <= '0;
      status_q      <= ST_OK;
      dom_res       <= 1'b0;
      chk_v         <= 1'b0;
      hit           <= 1'b0;
      ph            <= 1'b0;
      samp_en       <= 1'b0;
    end else begin
      if (cfg_valid) thr <= cfg_data;
      if (m_tvalid && m_tready && state != S_FIN) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req_q    <= req_t'(s_tuser);
            dom_q    <= s_tdata[30:0];
            sidx_q   <= s_tdata[34:31];
            now_q    <= s_tdata[98:35];
            status_q <= ST_OK;
            dom_res  <= 1'b0;
            state    <= S_DISPATCH;
          end
        end

        S_DISPATCH: begin
          ridx  <= '0;
          chk_v <= 1'b0;
          hit   <= 1'b0;
          case (req_q)
            REQ_ENTER: begin
              if (stalled_count == '0) some_start <= now_q;
              if (stalled_count != COUNT_MAX) stalled_count <= stalled_count + 1'b1;
              state <= S_SCAN;
            end
            REQ_EXIT: begin
              if (stalled_count == '0) begin
                status_q <= ST_UNDERFLOW;
              end else begin
                stalled_count <= stalled_count - 1'b1;
                if (stalled_count == CNT_W'(1) && now_q > some_start) begin
                  some_banked <= some_banked + (now_q - some_start);
                end
              end
              state <= S_SCAN;
            end
            REQ_BUSY: begin
              any_busy <= 1'b1;
              state    <= S_SCAN;
            end
            REQ_SAMPLE: begin
              samp_en <= (last_sample != '0) && (now_q > last_sample);
              dt      <= now_q - last_sample;
              if (last_sample != '0 && now_q > last_sample && stalled_count != '0
                  && !any_busy) begin
                full_banked <= full_banked + (now_q - last_sample);
              end
              last_sample <= now_q;
              any_busy    <= 1'b0;
              state       <= S_WALK;
            end
            REQ_AGGREGATE: begin
              period <= (now_q > last_agg) ? (now_q - last_agg) : NS_W'(1);
              g_some <= glive;
              g_full <= full_banked;
              ph     <= 1'b0;
              state  <= S_AG_START;
            end
            REQ_READ_DOMAIN: begin
              dom_res <= 1'b1;
              d_id    <= '0;
              d_inuse <= 1'b0;
              d_some  <= '0;
              d_full  <= '0;
              d_avg   <= '0;
              if (int'(sidx_q) < MAX_DOMAINS && slot_used[SLOT_W'(sidx_q)]) begin
                state <= S_RDDOM;
              end else begin
                state <= S_FIN;
              end
            end
            default: state <= S_FIN;
          endcase
        end

        S_SCAN: begin
          if (ridx != LAST_SLOT) ridx <= ridx + 1'b1;
          chk_v   <= 1'b1;
          chk_idx <= ridx;
          if (chk_v) begin
            if (!hit && slot_used[chk_idx] && mem_q.domain == dom_q) begin
              hit     <= 1'b1;
              hit_idx <= chk_idx;
              hit_rec <= mem_q;
            end
            if (chk_idx == LAST_SLOT) state <= S_APPLY;
          end
        end

        S_APPLY: begin
          if (req_q == REQ_BUSY) begin
            if (hit) busy_mask[hit_idx] <= 1'b1;
          end else if (!apply_can) begin
            if (status_q == ST_OK) status_q <= ST_TABLE_FULL;
          end else if (!hit) begin
            slot_used[free_idx] <= 1'b1;
          end
          state <= S_FIN;
        end

        S_WALK: begin
          if (ridx != LAST_SLOT) ridx <= ridx + 1'b1;
          chk_v   <= 1'b1;
          chk_idx <= ridx;
          if (chk_v && chk_idx == LAST_SLOT) begin
            busy_mask <= '0;
            state     <= S_FIN;
          end
        end

        S_AG_START: state <= S_AG_WAIT;

        S_AG_WAIT: begin
          if (div_done) begin
            if (!ph) begin
              gsome <= ew_out;
              ph    <= 1'b1;
              state <= S_AG_START;
            end else begin
              gfull     <= ew_out;
              prev_some <= g_some;
              prev_full <= g_full;
              last_agg  <= now_q;
              ridx      <= '0;
              state     <= S_AS_RD;
            end
          end
        end

        S_AS_RD: state <= S_AS_CHK;

        S_AS_CHK: begin
          if (slot_used[ridx]) begin
            arec  <= mem_q;
            ajf   <= q_jf;
            state <= S_AS_START;
          end else if (ridx == LAST_SLOT) begin
            state <= S_FIN;
          end else begin
            ridx  <= ridx + 1'b1;
            state <= S_AS_RD;
          end
        end

        S_AS_START: state <= S_AS_WAIT;

        S_AS_WAIT: begin
          if (div_done) begin
            if (ridx == LAST_SLOT) begin
              state <= S_FIN;
            end else begin
              ridx  <= ridx + 1'b1;
              state <= S_AS_RD;
            end
          end
        end

        S_RDDOM: begin
          d_id    <= mem_q.domain;
          d_inuse <= 1'b1;
          d_some  <= q_js;
          d_full  <= q_jf;
          d_avg   <= mem_q.avg;
          state   <= S_FIN;
        end

        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            o_status <= status_q;
            o_id     <= dom_res ? d_id : '0;
            o_inuse  <= dom_res ? d_inuse : 1'b0;
            o_some   <= dom_res ? d_some : glive;
            o_full   <= dom_res ? d_full : full_banked;
            o_bp[0]  <= to_bp(gsome[0]);
            o_bp[1]  <= to_bp(gsome[1]);
            o_bp[2]  <= to_bp(gsome[2]);
            o_bp[3]  <= to_bp(dom_res ? d_avg[0] : gfull[0]);
            o_bp[4]  <= to_bp(dom_res ? d_avg[1] : gfull[1]);
            o_bp[5]  <= to_bp(dom_res ? d_avg[2] : gfull[2]);
            o_above  <= (to_bp(gfull[0]) >= thr);
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {1'b0, o_above, o_bp[5], o_bp[4], o_bp[3], o_bp[2], o_bp[1], o_bp[0],
                    o_full, o_some, o_inuse, o_id, o_status};

  // accepted request holds off the next one until its result is formed
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in flight");

  a_underflow_flag: assert property (@(posedge clk) disable iff (rst)
    state == S_DISPATCH && req_q == REQ_EXIT && stalled_count == '0
    |=> status_q == ST_UNDERFLOW && stalled_count == '0)
    else $error("exit at zero count not flagged as underflow");

  a_slots_never_freed: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (slot_used & $past(slot_used)) == $past(slot_used))
    else $error("claimed slot released");

  a_div_only_when_aggregating: assert property (@(posedge clk) disable iff (rst)
    div_start |-> req_q == REQ_AGGREGATE)
    else $error("divider started outside aggregation");

endmodule
